// File: rtl/cbat_pkg.sv
`timescale 1ns / 1ps

package cbat_pkg;

  localparam int MAX_BUTTONS_DEF = 16;
  localparam int OP_W            = 2;
  localparam int BTN_W           = 4;
  localparam int CFG_W           = 5;

  localparam logic [CFG_W-1:0] BUTTONS_RESET = CFG_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_PRESS = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_SPARE = 2'd3
  } op_code_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [BTN_W-1:0] button_index;
  } item_t;

  typedef struct packed {
    logic [BTN_W-1:0] oldest_button;
    logic             any_lit;
    logic             addressed_lit;
    logic             bad_index;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic commit;
    logic cfg_we;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// File: rtl/cbat_ifs.sv
`timescale 1ns / 1ps

interface cbat_req_if import cbat_pkg::*;;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbat_rsp_if import cbat_pkg::*;;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbat_cfg_if import cbat_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/call_button_age_tracker_unit.sv
`timescale 1ns / 1ps
// Each item takes two turns of the entry ring: one to fetch the addressed entry, one to update
//   ranks and find the oldest lit button. A new item is taken only once the last one is finished.
// A finished result sits in the output register while the next item is taken in.
// Reset (rst, synchronous): all buttons unlit, ranks and count zero, buttons_in_use = 16.

module call_button_age_tracker_unit import cbat_pkg::*; #(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
  input logic        clk,
  input logic        rst,
  cbat_req_if.sink   req,
  cbat_rsp_if.source rsp,
  cbat_cfg_if.sink   cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  cbat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cfg_valid (cfg.valid),
    .cmd       (cmd),
    .status    (status)
  );

  cbat_datapath #(
    .MAX_BUTTONS (MAX_BUTTONS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .item     (req.data),
    .cfg_data (cfg.data),
    .result   (rsp.data)
  );

  // a rejected item never reports its button as lit
  a_bad_not_lit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.bad_index |-> !rsp.data.addressed_lit)
    else $error("bad index reported with addressed button lit");

  a_none_lit_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.any_lit |-> (rsp.data.oldest_button == '0))
    else $error("oldest button nonzero with no button lit");

  a_lit_any: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.addressed_lit |-> rsp.data.any_lit)
    else $error("addressed button lit but no button lit");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("new item taken while one is in progress");

endmodule

// File: rtl/cbat_ctrl.sv
`timescale 1ns / 1ps

module cbat_ctrl import cbat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  logic       cfg_valid,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.apply  = (state == S_APPLY);
    cmd.commit = (state == S_FINISH) && out_free;
    cmd.cfg_we = cfg_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // a new result may replace one that leaves in the same cycle
      if ((state == S_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (status.last) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (status.last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/cbat_datapath.sv
`timescale 1ns / 1ps

module cbat_datapath import cbat_pkg::*; #(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  input  item_t            item,
  input  logic [CFG_W-1:0] cfg_data,
  output result_t          result
);

  localparam int IDX_W  = $clog2(MAX_BUTTONS);
  localparam int RANK_W = $clog2(MAX_BUTTONS + 1);

  // entry ring: position 0 is the head, the ring turns one place per step
  logic              lit_ring  [MAX_BUTTONS];
  logic [RANK_W-1:0] rank_ring [MAX_BUTTONS];

  logic [CFG_W-1:0]  buttons_in_use;
  logic [IDX_W-1:0]  cnt;
  logic [OP_W-1:0]   op_q;
  logic [BTN_W-1:0]  idx_q;
  logic              bad_q;
  logic              lit_b;
  logic [RANK_W-1:0] rank_b;
  logic [RANK_W-1:0] lit_count;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic [RANK_W-1:0] best_rank;

  logic              is_press;
  logic              is_clear;
  logic              act;
  logic              is_tgt;
  logic              bad_in;
  logic              head_lit_next;
  logic [RANK_W-1:0] head_rank_next;
  logic [RANK_W-1:0] lit_count_next;
  logic              addr_lit;

  assign status.last = (cnt == IDX_W'(MAX_BUTTONS - 1));

  assign bad_in = (32'(item.button_index) >= 32'(buttons_in_use)) ||
                  (32'(item.button_index) >= MAX_BUTTONS);

  assign is_press = (op_q == OP_PRESS);
  assign is_clear = (op_q == OP_CLEAR);
  // clear of an unlit button and queries leave the state alone
  assign act      = !bad_q && (is_press || (is_clear && lit_b));
  assign is_tgt   = (32'(cnt) == 32'(idx_q));

  always_comb begin
    head_lit_next  = lit_ring[0];
    head_rank_next = rank_ring[0];
    if (act) begin
      if (is_tgt) begin
        if (is_press) begin
          head_lit_next  = 1'b1;
          head_rank_next = lit_b ? lit_count : lit_count + RANK_W'(1);
        end else begin
          head_lit_next  = 1'b0;
          head_rank_next = '0;
        end
      end else if (lit_b && lit_ring[0] && (rank_ring[0] > rank_b)) begin
        head_rank_next = rank_ring[0] - RANK_W'(1);
      end
    end
  end

  always_comb begin
    lit_count_next = lit_count;
    if (act && is_press && !lit_b) begin
      lit_count_next = lit_count + RANK_W'(1);
    end else if (act && is_clear) begin
      lit_count_next = lit_count - RANK_W'(1);
    end
  end

  always_comb begin
    if (bad_q) begin
      addr_lit = 1'b0;
    end else if (is_press) begin
      addr_lit = 1'b1;
    end else if (is_clear) begin
      addr_lit = 1'b0;
    end else begin
      addr_lit = lit_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buttons_in_use <= BUTTONS_RESET;
      lit_count      <= '0;
      for (int i = 0; i < MAX_BUTTONS; i++) begin
        lit_ring[i]  <= 1'b0;
        rank_ring[i] <= '0;
      end
    end else begin
      if (cmd.cfg_we) begin
        buttons_in_use <= cfg_data;
      end
      if (cmd.scan || cmd.apply) begin
        for (int i = 0; i < MAX_BUTTONS - 1; i++) begin
          lit_ring[i]  <= lit_ring[i+1];
          rank_ring[i] <= rank_ring[i+1];
        end
        lit_ring[MAX_BUTTONS-1]  <= cmd.apply ? head_lit_next : lit_ring[0];
        rank_ring[MAX_BUTTONS-1] <= cmd.apply ? head_rank_next : rank_ring[0];
      end
      if (cmd.commit) begin
        lit_count <= lit_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= item.operation;
      idx_q     <= item.button_index;
      bad_q     <= bad_in;
      cnt       <= '0;
      lit_b     <= 1'b0;
      rank_b    <= '0;
      found     <= 1'b0;
      best_idx  <= '0;
      best_rank <= '0;
    end else if (cmd.scan || cmd.apply) begin
      cnt <= status.last ? '0 : cnt + IDX_W'(1);
      if (cmd.scan && is_tgt) begin
        lit_b  <= lit_ring[0];
        rank_b <= rank_ring[0];
      end
      // ascending index order with a strict compare: lowest index wins ties
      if (cmd.apply && head_lit_next && (!found || head_rank_next < best_rank)) begin
        found     <= 1'b1;
        best_idx  <= cnt;
        best_rank <= head_rank_next;
      end
    end
    if (cmd.commit) begin
      result.oldest_button <= found ? BTN_W'(best_idx) : '0;
      result.any_lit       <= (lit_count_next != '0);
      result.addressed_lit <= addr_lit;
      result.bad_index     <= bad_q;
    end
  end

endmodule
